// File: src/assert_macros.svh
// Assertion macros shared by the table_atan2_angle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: src/tatan_pkg.sv
// Package with types, constants and the atan table function of the angle block.
`timescale 1ns / 1ps

package tatan_pkg;

   // Default table size and field widths
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int COORD_W         = 16;
   localparam int MAG_W           = COORD_W + 1;
   localparam int ATAN_W          = 13;
   localparam int HALF_W          = 15;
   localparam int FULL_W          = 16;
   localparam int ANG_W           = 18;

   // Angles in Q13 radians, real value rounded to nearest
   localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 18'sd12868;
   localparam logic signed [ANG_W-1:0] PI_Q13      = 18'sd25736;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q13  = 18'sd51472;

   // One radian in Q13
   localparam real ATAN_ONE = 8192.0;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
   } tatan_req_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] half_angle;
      logic        [FULL_W-1:0] full_angle;
      logic                     both_zero;
   } tatan_rsp_type;

   // Octant information that rides along with the index
   typedef struct packed {
      logic xneg;
      logic yneg;
      logic swap;
      logic zero;
   } tatan_side_type;

   // atan of a ratio in [0,1], Q13, rounded to nearest; elaboration only
   function automatic logic [ATAN_W-1:0] tatan_atan_q13(input real ratio);
      real ang;
      ang = $atan(ratio) * ATAN_ONE;
      return ATAN_W'($rtoi(ang + 0.5));
   endfunction

endpackage

// File: src/table_atan2_angle.sv
// Top level: angle of a signed coordinate pair by division and atan table lookup.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   req channel: one beat carries x_coord and y_coord (signed 16 bits each).
//   rsp channel: one beat per request, in order, with half_angle (folded,
//   [-pi/2, pi/2]), full_angle ([0, 2pi]) and both_zero, all in Q13 radians.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Pipeline: a request beat passes one stage for magnitude compare, one
//   for the numerator multiply, one per index bit in the restoring divider,
//   one for the table read and one output register.
// Throughput: one beat per cycle while rsp_ready is high; the divider is fully
//   pipelined and the table RAM takes one read per cycle.
// Reset: the atan table is loaded by a sweep over every address after
//   reset; req_ready stays low until it ends.
// Stall: with rsp_ready low, results back up stage by stage; empty stages
//   keep filling, so req_ready drops only when every stage holds a beat.

module table_atan2_angle
   import tatan_pkg::*;
#(
   parameter int TableDepth = TABLE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  tatan_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output tatan_rsp_type rsp_data
);

   localparam int IdxW = $clog2(TableDepth);
   localparam int NumW = IdxW + MAG_W;
   localparam logic [IdxW-1:0] DEPTH_M1 = IdxW'(TableDepth - 1);

   logic                    en_s0, en_s1, en_rom, en_rsp;
   logic                    fill_done;

   logic                    xneg, yneg;
   logic [MAG_W-1:0]        ax, ay;
   logic                    vld_s0_ff, vld_s0_in;
   logic [MAG_W-1:0]        small_s0_ff, small_s0_in;
   logic [MAG_W-1:0]        large_s0_ff, large_s0_in;
   tatan_side_type          side_s0_ff, side_s0_in;

   logic [NumW-1:0]         prod;
   logic                    vld_s1_ff, vld_s1_in;
   logic [NumW-1:0]         num_s1_ff, num_s1_in;
   logic [MAG_W-1:0]        den_s1_ff, den_s1_in;
   tatan_side_type          side_s1_ff, side_s1_in;

   logic                    div_en_in;
   logic                    div_vld;
   logic [IdxW-1:0]         div_q;
   tatan_side_type          div_side;

   logic [ATAN_W-1:0]       rom_data;
   logic                    vld_rom_ff, vld_rom_in;
   tatan_side_type          side_rom_ff, side_rom_in;

   logic signed [ANG_W-1:0] entry;
   logic signed [ANG_W-1:0] half;
   logic signed [ANG_W-1:0] full;
   logic                    rsp_valid_ff, rsp_valid_in;
   tatan_rsp_type           rsp_data_ff, rsp_data_in;

   // Back-pressure chain: a stage moves when empty or its successor moves
   assign en_rsp    = !rsp_valid_ff || rsp_ready;
   assign en_rom    = !vld_rom_ff || en_rsp;
   assign en_s1     = !vld_s1_ff || div_en_in;
   assign en_s0     = !vld_s0_ff || en_s1;
   assign req_ready = en_s0 && fill_done;

   // Stage 0: magnitudes, compare, octant
   always_comb begin
      xneg = req_data.x_coord[COORD_W-1];
      yneg = req_data.y_coord[COORD_W-1];
      ax   = xneg ? (MAG_W'(1) << COORD_W) - {1'b0, req_data.x_coord}
                  : {1'b0, req_data.x_coord};
      ay   = yneg ? (MAG_W'(1) << COORD_W) - {1'b0, req_data.y_coord}
                  : {1'b0, req_data.y_coord};
      side_s0_in.xneg = xneg;
      side_s0_in.yneg = yneg;
      side_s0_in.swap = ay > ax;
      side_s0_in.zero = (ax == '0) && (ay == '0);
      small_s0_in     = side_s0_in.swap ? ax : ay;
      large_s0_in     = side_s0_in.swap ? ay : ax;
      vld_s0_in       = en_s0 ? (req_valid && req_ready) : vld_s0_ff;
   end

   // Stage 1: numerator 2*small*(depth-1) + large, divisor 2*large; 0 and 2 for a zero input
   always_comb begin
      prod       = small_s0_ff * DEPTH_M1;
      num_s1_in  = side_s0_ff.zero ? '0 : (prod << 1) + NumW'(large_s0_ff);
      den_s1_in  = side_s0_ff.zero ? MAG_W'(2) : large_s0_ff << 1;
      side_s1_in = side_s0_ff;
      vld_s1_in  = en_s1 ? vld_s0_ff : vld_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s0_ff <= 1'b0;
         vld_s1_ff <= 1'b0;
      end else begin
         vld_s0_ff <= vld_s0_in;
         vld_s1_ff <= vld_s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s0) begin
         small_s0_ff <= small_s0_in;
         large_s0_ff <= large_s0_in;
         side_s0_ff  <= side_s0_in;
      end
      if (en_s1) begin
         num_s1_ff  <= num_s1_in;
         den_s1_ff  <= den_s1_in;
         side_s1_ff <= side_s1_in;
      end
   end

   tatan_div #(
      .Depth (TableDepth)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_s1_ff),
      .in_num   (num_s1_ff),
      .in_den   (den_s1_ff),
      .in_side  (side_s1_ff),
      .en_in    (div_en_in),
      .en_out   (en_rom),
      .out_vld  (div_vld),
      .out_q    (div_q),
      .out_side (div_side)
   );

   // Table read stage; RAM data register moves with this stage
   tatan_rom #(
      .Depth (TableDepth)
   ) u_rom (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (en_rom),
      .rd_addr   (div_q),
      .rd_data   (rom_data),
      .fill_done (fill_done)
   );

   assign vld_rom_in  = en_rom ? div_vld : vld_rom_ff;
   assign side_rom_in = div_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_rom_ff <= 1'b0;
      end else begin
         vld_rom_ff <= vld_rom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_rom) begin
         side_rom_ff <= side_rom_in;
      end
   end

   // Fold the table entry by octant, then correct by quadrant
   always_comb begin
      entry = signed'(ANG_W'(rom_data));
      if (side_rom_ff.zero) begin
         half = '0;
      end else if (!side_rom_ff.swap) begin
         half = (side_rom_ff.xneg ^ side_rom_ff.yneg) ? -entry : entry;
      end else begin
         half = (side_rom_ff.xneg ^ side_rom_ff.yneg) ? entry - HALF_PI_Q13
                                                      : HALF_PI_Q13 - entry;
      end

      if (side_rom_ff.zero) begin
         full = '0;
      end else if (!side_rom_ff.xneg) begin
         full = side_rom_ff.yneg ? half + TWO_PI_Q13 : half;
      end else begin
         full = half + PI_Q13;
      end

      rsp_data_in.half_angle = half[HALF_W-1:0];
      rsp_data_in.full_angle = full[FULL_W-1:0];
      rsp_data_in.both_zero  = side_rom_ff.zero;
      rsp_valid_in           = en_rsp ? vld_rom_ff : rsp_valid_ff;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_no_req_in_fill, clock, reset, !fill_done |-> !req_ready, "request taken during table fill")
   `ASSERT_CLK(a_zero_angles, clock, reset, rsp_valid_ff && rsp_data_ff.both_zero |-> rsp_data_ff.half_angle == '0 && rsp_data_ff.full_angle == '0, "zero input gave nonzero angle")
   `ASSERT_CLK(a_half_range, clock, reset, rsp_valid_ff |-> rsp_data_ff.half_angle >= -HALF_PI_Q13 && rsp_data_ff.half_angle <= HALF_PI_Q13, "half angle out of range")
   `ASSERT_CLK(a_full_range, clock, reset, rsp_valid_ff |-> ANG_W'(rsp_data_ff.full_angle) <= TWO_PI_Q13, "full angle out of range")

endmodule

// File: src/tatan_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tatan_ram #(
   parameter int   Width = 8,
   parameter int   Depth = 16,
   localparam int  AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tatan_div.sv
// Pipelined restoring divider: one quotient bit per stage, gives the table index.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tatan_div
   import tatan_pkg::*;
#(
   parameter int  Depth = TABLE_DEPTH_DEF,
   localparam int IdxW  = $clog2(Depth),
   localparam int NumW  = IdxW + MAG_W
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_vld,
   input  logic [NumW-1:0] in_num,
   input  logic [MAG_W-1:0] in_den,
   input  tatan_side_type  in_side,
   output logic            en_in,
   input  logic            en_out,
   output logic            out_vld,
   output logic [IdxW-1:0] out_q,
   output tatan_side_type  out_side
);

   localparam logic [IdxW-1:0] DEPTH_M1 = IdxW'(Depth - 1);

   logic                    vld_ff  [IdxW];
   logic                    vld_in  [IdxW];
   logic [NumW-1:0]         rem_ff  [IdxW];
   logic [NumW-1:0]         rem_in  [IdxW];
   logic [MAG_W-1:0]        den_ff  [IdxW];
   logic [MAG_W-1:0]        den_in  [IdxW];
   logic [IdxW-1:0]         q_ff    [IdxW];
   logic [IdxW-1:0]         q_in    [IdxW];
   tatan_side_type          side_ff [IdxW];
   tatan_side_type          side_in [IdxW];
   logic [IdxW:0]           en_chain;

   // A stage advances when it is empty or its successor advances
   always_comb begin
      en_chain[IdxW] = en_out;
      for (int k = IdxW - 1; k >= 0; k--) begin
         en_chain[k] = !vld_ff[k] || en_chain[k+1];
      end
   end

   assign en_in = en_chain[0];

   for (genvar k = 0; k < IdxW; k++) begin : g_stage
      localparam int Bit = IdxW - 1 - k;

      logic                 vld_prev;
      logic [NumW-1:0]      rem_prev;
      logic [MAG_W-1:0]     den_prev;
      logic [IdxW-1:0]      q_prev;
      tatan_side_type       side_prev;
      logic [NumW-1:0]      trial;
      logic                 fits;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = in_num;
         assign den_prev  = in_den;
         assign q_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Try the shifted divisor and keep the remainder if it fits
      assign trial      = NumW'(den_prev) << Bit;
      assign fits       = rem_prev >= trial;
      assign rem_in[k]  = fits ? rem_prev - trial : rem_prev;
      assign q_in[k]    = q_prev | (IdxW'(fits) << Bit);
      assign den_in[k]  = den_prev;
      assign side_in[k] = side_prev;
      assign vld_in[k]  = en_chain[k] ? vld_prev : vld_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en_chain[k]) begin
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            q_ff[k]    <= q_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[IdxW-1];
   assign out_q    = q_ff[IdxW-1];
   assign out_side = side_ff[IdxW-1];

   `ASSERT_CLK(a_q_in_range, clock, reset, out_vld |-> out_q <= DEPTH_M1, "index beyond table")
   `ASSERT_CLK(a_out_hold, clock, reset, out_vld && !en_out |=> out_vld && $stable(out_q), "stalled index moved")
   `ASSERT_NEVER(a_den_zero, clock, reset, in_vld && en_chain[0] && in_den == '0, "zero divisor entered")

endmodule

// File: src/tatan_rom.sv
// atan table in a RAM, loaded by a sweep after reset and read through a registered output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tatan_rom
   import tatan_pkg::*;
#(
   parameter int  Depth = TABLE_DEPTH_DEF,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AddrW-1:0]  rd_addr,
   output logic [ATAN_W-1:0] rd_data,
   output logic              fill_done
);

   localparam logic [AddrW-1:0] LAST_ADDR = AddrW'(Depth - 1);

   logic [ATAN_W-1:0] init_tab [Depth];
   logic [AddrW-1:0]  fill_cnt_ff;
   logic [AddrW-1:0]  fill_cnt_in;
   logic              fill_done_ff;
   logic              fill_done_in;
   logic              wr_en;

   // Table contents, worked out at elaboration
   for (genvar g = 0; g < Depth; g++) begin : g_init
      localparam logic [ATAN_W-1:0] Entry = tatan_atan_q13(real'(g) / real'(Depth - 1));
      assign init_tab[g] = Entry;
   end

   // Sweep every address once after reset, then stop
   always_comb begin
      wr_en        = !fill_done_ff;
      fill_done_in = fill_done_ff || (fill_cnt_ff == LAST_ADDR);
      fill_cnt_in  = fill_done_in ? fill_cnt_ff : fill_cnt_ff + AddrW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff  <= '0;
         fill_done_ff <= 1'b0;
      end else begin
         fill_cnt_ff  <= fill_cnt_in;
         fill_done_ff <= fill_done_in;
      end
   end

   // Table is never written after the sweep, so reads need no forwarding
   tatan_ram #(
      .Width (ATAN_W),
      .Depth (Depth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_cnt_ff),
      .wr_data (init_tab[fill_cnt_ff]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fill_done = fill_done_ff;

   `ASSERT_CLK(a_fill_sticky, clock, reset, fill_done_ff |=> fill_done_ff, "fill done dropped")
   `ASSERT_CLK(a_fill_end, clock, reset, wr_en && fill_cnt_ff == LAST_ADDR |=> fill_done_ff, "sweep overran")
   `ASSERT_CLK(a_cnt_hold, clock, reset, fill_done_ff |=> $stable(fill_cnt_ff), "counter moved after fill")

endmodule
